/* rtl/core/tccwa_pkg.sv */
// Shared types, constants and helpers for the three-channel calibrated window alarm.
`default_nettype none

package tccwa_pkg;

	localparam int ADC_BITS = 10;
	localparam int NCH      = 3;
	localparam int N_FWD    = 2;
	localparam int INV_CH   = 2;
	localparam int TRIM_W   = 8;
	localparam int LIMIT_W  = 10;
	localparam int TEMP_W   = 11;
	localparam int ZONE_W   = 2;
	localparam int LED_W    = 3 * NCH;

	localparam int IN_FIELDS_W  = NCH * ADC_BITS + 3;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = NCH * TEMP_W + NCH * ZONE_W + LED_W + 2;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT_CH1  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT_CH1 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT_CH2  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT_CH2 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT_CH3  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT_CH3 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_TRIMS     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TRIMS   = 4'd7;

	localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST_FWD  = 10'd30;
	localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST_FWD = 10'd100;
	localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST_INV  = 10'd100;
	localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST_INV = 10'd759;

	// Forward channels: (adc + offset) * (FULLSCALE + GAIN_STEP * gain) / SCALE_DIV
	localparam int FULLSCALE = 1500;
	localparam int GAIN_STEP = 10;
	localparam int SCALE_DIV = 10230;
	// Inverted channel: -((INV_GAIN + gain) * adc) / INV_DIV + INV_BASE + offset
	localparam int INV_GAIN  = 760;
	localparam int INV_DIV   = 819;
	localparam int INV_BASE  = 855;

	localparam int SUM_W     = ADC_BITS + 2;
	localparam int MAG_SUM_W = ADC_BITS + 1;
	localparam int SCALE_W   = 12;
	localparam int MAG1_W    = MAG_SUM_W + SCALE_W;
	localparam int S1        = MAG1_W + $clog2(SCALE_DIV);
	localparam longint K1    = ((longint'(1) << S1) + SCALE_DIV - 1) / SCALE_DIV;
	localparam int K1_W      = $clog2(K1 + 1);
	localparam int PR1_W     = MAG1_W + K1_W;
	localparam int Q1_W      = PR1_W - S1;

	localparam int GAIN3_W   = 10;
	localparam int P3_W      = ADC_BITS + GAIN3_W;
	localparam int S3        = P3_W + $clog2(INV_DIV);
	localparam longint K3    = ((longint'(1) << S3) + INV_DIV - 1) / INV_DIV;
	localparam int K3_W      = $clog2(K3 + 1);
	localparam int PR3_W     = P3_W + K3_W;
	localparam int Q3_W      = PR3_W - S3;

	localparam int WIDE_W = 14;
	localparam int CMP_W  = TEMP_W + 1;
	localparam logic signed [WIDE_W-1:0] WIDE_TEMP_MAX = WIDE_W'(2 ** (TEMP_W - 1) - 1);
	localparam logic signed [WIDE_W-1:0] WIDE_TEMP_MIN = -WIDE_W'(2 ** (TEMP_W - 1));

	typedef enum logic [ZONE_W-1:0] {
		ZONE_NORMAL = 2'd0,
		ZONE_HIGH   = 2'd1,
		ZONE_LOW    = 2'd2
	} zone_t;

	typedef struct packed {
		logic [NCH-1:0][ADC_BITS-1:0] adc;
		logic                         blink_phase;
		logic                         test_mode;
		logic                         sound_toggle;
	} in_item_t;

	typedef struct packed {
		logic [NCH-1:0][LIMIT_W-1:0] low_limit;
		logic [NCH-1:0][LIMIT_W-1:0] high_limit;
		logic [NCH-1:0][TRIM_W-1:0]  gain;
		logic [NCH-1:0][TRIM_W-1:0]  offset;
	} cfg_t;

	typedef struct packed {
		logic                  s1;
		logic                  s2;
		logic                  s3;
		logic                  out;
		logic                  commit;
	} pipe_en_t;

	typedef struct packed {
		logic [N_FWD-1:0]            neg;
		logic [N_FWD-1:0][Q1_W-1:0]  q_fwd;
		logic [Q3_W-1:0]             q_inv;
		logic                        blink_phase;
		logic                        test_mode;
		logic                        sound_toggle;
	} cal_t;

	typedef struct packed {
		logic                       sound_on;
		logic                       relay_on;
		logic [LED_W-1:0]           led_drive;
		zone_t [NCH-1:0]            zone;
		logic [NCH-1:0][TEMP_W-1:0] temp;
	} out_item_t;

	function automatic logic [TEMP_W-1:0] sat_temp(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] c;
		c = v;
		if (v > WIDE_TEMP_MAX) begin
			c = WIDE_TEMP_MAX;
		end else if (v < WIDE_TEMP_MIN) begin
			c = WIDE_TEMP_MIN;
		end
		return c[TEMP_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tccwa_cfg_regs.sv */
// Configuration register file: alarm limits and packed gain and offset trims.
`default_nettype none

module tccwa_cfg_regs import tccwa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit  <= {LOW_LIMIT_RST_INV, LOW_LIMIT_RST_FWD, LOW_LIMIT_RST_FWD};
			cfg_q.high_limit <= {HIGH_LIMIT_RST_INV, HIGH_LIMIT_RST_FWD, HIGH_LIMIT_RST_FWD};
			cfg_q.gain       <= '0;
			cfg_q.offset     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LOW_LIMIT_CH1:  cfg_q.low_limit[0]  <= wr_data[LIMIT_W-1:0];
				REG_HIGH_LIMIT_CH1: cfg_q.high_limit[0] <= wr_data[LIMIT_W-1:0];
				REG_LOW_LIMIT_CH2:  cfg_q.low_limit[1]  <= wr_data[LIMIT_W-1:0];
				REG_HIGH_LIMIT_CH2: cfg_q.high_limit[1] <= wr_data[LIMIT_W-1:0];
				REG_LOW_LIMIT_CH3:  cfg_q.low_limit[2]  <= wr_data[LIMIT_W-1:0];
				REG_HIGH_LIMIT_CH3: cfg_q.high_limit[2] <= wr_data[LIMIT_W-1:0];
				REG_GAIN_TRIMS:     cfg_q.gain          <= wr_data[NCH*TRIM_W-1:0];
				REG_OFFSET_TRIMS:   cfg_q.offset        <= wr_data[NCH*TRIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/tccwa_cal.sv */
// Calibration pipeline: input register, trim products, reciprocal-multiply division.
`default_nettype none

module tccwa_cal import tccwa_pkg::*; (
	input  wire logic     clk,
	input  wire pipe_en_t en,
	input  wire in_item_t in_item,
	input  wire cfg_t     cfg,
	output cal_t          cal_s3
);

	in_item_t                    item_s1;
	logic [N_FWD-1:0][MAG1_W-1:0] mag_s2;
	logic [N_FWD-1:0]            neg_s2;
	logic [P3_W-1:0]             p3_s2;
	logic                        blink_s2;
	logic                        test_s2;
	logic                        toggle_s2;

	logic signed [SUM_W-1:0]     sum     [N_FWD];
	logic [MAG_SUM_W-1:0]        mag_sum [N_FWD];
	logic signed [SCALE_W:0]     scale   [N_FWD];
	logic signed [GAIN3_W:0]     gain3;
	logic [PR1_W-1:0]            pr1     [N_FWD];
	logic [PR3_W-1:0]            pr3;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		for (int ch = 0; ch < N_FWD; ch++) begin
			sum[ch] = $signed({2'b00, item_s1.adc[ch]})
				+ $signed({{(SUM_W-TRIM_W){cfg.offset[ch][TRIM_W-1]}}, cfg.offset[ch]});
			mag_sum[ch] = sum[ch][SUM_W-1] ? MAG_SUM_W'(-sum[ch]) : MAG_SUM_W'(sum[ch]);
			scale[ch] = $signed((SCALE_W+1)'(FULLSCALE))
				+ $signed({{(SCALE_W+1-TRIM_W){cfg.gain[ch][TRIM_W-1]}}, cfg.gain[ch]})
				* $signed((SCALE_W+1)'(GAIN_STEP));
		end
		gain3 = $signed((GAIN3_W+1)'(INV_GAIN))
			+ $signed({{(GAIN3_W+1-TRIM_W){cfg.gain[INV_CH][TRIM_W-1]}}, cfg.gain[INV_CH]});
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int ch = 0; ch < N_FWD; ch++) begin
				mag_s2[ch] <= MAG1_W'(mag_sum[ch]) * MAG1_W'(scale[ch][SCALE_W-1:0]);
				neg_s2[ch] <= sum[ch][SUM_W-1];
			end
			p3_s2     <= P3_W'(item_s1.adc[INV_CH]) * P3_W'(gain3[GAIN3_W-1:0]);
			blink_s2  <= item_s1.blink_phase;
			test_s2   <= item_s1.test_mode;
			toggle_s2 <= item_s1.sound_toggle;
		end
	end

	always_comb begin
		for (int ch = 0; ch < N_FWD; ch++) begin
			pr1[ch] = PR1_W'(mag_s2[ch]) * PR1_W'(K1);
		end
		pr3 = PR3_W'(p3_s2) * PR3_W'(K3);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int ch = 0; ch < N_FWD; ch++) begin
				cal_s3.q_fwd[ch] <= pr1[ch][PR1_W-1 -: Q1_W];
				cal_s3.neg[ch]   <= neg_s2[ch];
			end
			cal_s3.q_inv        <= pr3[PR3_W-1 -: Q3_W];
			cal_s3.blink_phase  <= blink_s2;
			cal_s3.test_mode    <= test_s2;
			cal_s3.sound_toggle <= toggle_s2;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/tccwa_alarm.sv */
// Result stage: saturation, zone compare, LED and relay drive, sound state.
`default_nettype none

module tccwa_alarm import tccwa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire pipe_en_t en,
	input  wire cal_t     cal_s3,
	input  wire cfg_t     cfg,
	output out_item_t     res_q
);

	logic [NCH-1:0]           prev_alarm_q;
	logic                     sound_q;

	logic signed [WIDE_W-1:0] wide  [NCH];
	logic [NCH-1:0][TEMP_W-1:0] temp;
	logic signed [CMP_W-1:0]  t_cmp [NCH];
	zone_t [NCH-1:0]          zone;
	logic [NCH-1:0]           alarm;
	logic [LED_W-1:0]         led;
	logic                     sound_next;
	logic                     relay;

	always_comb begin
		for (int ch = 0; ch < N_FWD; ch++) begin
			wide[ch] = cal_s3.neg[ch] ? -$signed(WIDE_W'(cal_s3.q_fwd[ch]))
				: $signed(WIDE_W'(cal_s3.q_fwd[ch]));
		end
		wide[INV_CH] = $signed(WIDE_W'(INV_BASE))
			+ $signed({{(WIDE_W-TRIM_W){cfg.offset[INV_CH][TRIM_W-1]}}, cfg.offset[INV_CH]})
			- $signed(WIDE_W'(cal_s3.q_inv));

		for (int ch = 0; ch < NCH; ch++) begin
			temp[ch]  = sat_temp(wide[ch]);
			t_cmp[ch] = $signed({{(CMP_W-TEMP_W){temp[ch][TEMP_W-1]}}, temp[ch]});
			priority if (t_cmp[ch] < $signed({{(CMP_W-LIMIT_W){1'b0}}, cfg.low_limit[ch]})) begin
				zone[ch] = ZONE_LOW;
			end else if (t_cmp[ch]
				> $signed({{(CMP_W-LIMIT_W){1'b0}}, cfg.high_limit[ch]})) begin
				zone[ch] = ZONE_HIGH;
			end else begin
				zone[ch] = ZONE_NORMAL;
			end
			alarm[ch] = (zone[ch] != ZONE_NORMAL);
			led[3*ch]     = cal_s3.test_mode || (zone[ch] == ZONE_NORMAL);
			led[3*ch + 1] = cal_s3.test_mode || ((zone[ch] == ZONE_HIGH) && cal_s3.blink_phase);
			led[3*ch + 2] = cal_s3.test_mode || ((zone[ch] == ZONE_LOW) && cal_s3.blink_phase);
		end

		// rising alarm sets sound, toggle request then inverts it
		sound_next = (sound_q || (|(alarm & ~prev_alarm_q))) ^ cal_s3.sound_toggle;
		relay      = (|alarm) && sound_next && cal_s3.blink_phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_alarm_q <= '0;
			sound_q      <= 1'b0;
		end else if (en.commit) begin
			prev_alarm_q <= alarm;
			sound_q      <= sound_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en.out) begin
			res_q.temp      <= temp;
			res_q.zone      <= zone;
			res_q.led_drive <= led;
			res_q.relay_on  <= relay;
			res_q.sound_on  <= sound_next;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/three_channel_calibrated_window_alarm.sv */
// Top level: stream ports, pipeline valid and stall control, field packing.
//
//   channel   direction  handshake              payload
//   s_        in         s_tvalid / s_tready    s_tdata  : three samples and control bits
//   m_        out        m_tvalid / m_tready    m_tdata  : readings, zones, LEDs, relay
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data : register write
//
// One item per cycle while the result side is not stalled; a result is offered once
// its input has passed through each register in order (input register, product register,
// quotient register, result register).
// Reset clears the stage valids, the alarm history and the sound flag, and
// loads the register defaults. A stalled result holds in the result register
// while bubbles ahead of it still fill, so input transfers continue until
// all four stages hold items.
`default_nettype none

module three_channel_calibrated_window_alarm import tccwa_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// adc_ch1, adc_ch2, adc_ch3, blink_phase, test_mode, sound_toggle, zero fill
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// temp_ch1, temp_ch2, temp_ch3, zone_ch1, zone_ch2, zone_ch3, led_drive,
	// relay_on, sound_on, zero fill
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic      valid_s1;
	logic      valid_s2;
	logic      valid_s3;
	logic      out_valid_q;
	pipe_en_t  en;
	in_item_t  in_item;
	cfg_t      cfg;
	cal_t      cal_s3;
	out_item_t res_q;

	always_comb begin
		en.out    = !out_valid_q || m_tready;
		en.s3     = !valid_s3 || en.out;
		en.s2     = !valid_s2 || en.s3;
		en.s1     = !valid_s1 || en.s2;
		en.commit = en.out && valid_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en.s1) begin
				valid_s1 <= s_tvalid;
			end
			if (en.s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_comb begin
		in_item.adc          = s_tdata[NCH*ADC_BITS-1:0];
		in_item.blink_phase  = s_tdata[NCH*ADC_BITS];
		in_item.test_mode    = s_tdata[NCH*ADC_BITS + 1];
		in_item.sound_toggle = s_tdata[NCH*ADC_BITS + 2];
	end

	tccwa_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tccwa_cal u_cal (
		.clk     (clk),
		.en      (en),
		.in_item (in_item),
		.cfg     (cfg),
		.cal_s3  (cal_s3)
	);

	tccwa_alarm u_alarm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cal_s3 (cal_s3),
		.cfg    (cfg),
		.res_q  (res_q)
	);

	assign s_tready  = en.s1;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {(OUT_TDATA_W-OUT_FIELDS_W)'(0), res_q.sound_on, res_q.relay_on,
		res_q.led_drive, res_q.zone, res_q.temp};

endmodule

`default_nettype wire

/* rtl/core/tccwa_checker.sv */
// Port-level checker for the window alarm, bound to the top level.
`default_nettype none

module tccwa_checker import tccwa_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic [IN_TDATA_W-1:0]  s_tdata,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic [CFG_IDX_W-1:0]   cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while result register empty");

	a_relay_sound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[49])
		else $error("relay on with sound off");

	a_normal_led: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[34:33] == 2'b00) |-> m_tdata[39])
		else $error("channel one normal zone without normal LED");

endmodule

bind three_channel_calibrated_window_alarm tccwa_checker u_tccwa_checker (.*);

`default_nettype wire
